// ----- rtl/fqvc_pkg.sv -----
// ----------------------------------------------------------------------------
// fqvc_pkg
// Shared types and constants for the field quad vote counter.
// ----------------------------------------------------------------------------
package fqvc_pkg;

  localparam int STAR_DEPTH = 4096;
  localparam int QUAD_DEPTH = 65536;
  localparam int VOTE_DEPTH = 64;
  localparam int STAR_AW    = $clog2(STAR_DEPTH);
  localparam int QUAD_AW    = $clog2(QUAD_DEPTH);
  localparam int VOTE_AW    = $clog2(VOTE_DEPTH);
  localparam int CFG_W      = 13;

  localparam logic [0:0] REG_STAR_COUNT     = 1'd0;
  localparam logic [0:0] REG_VOTE_THRESHOLD = 1'd1;

  localparam logic [1:0] CMD_LOAD_STAR = 2'd0;
  localparam logic [1:0] CMD_LOAD_QUAD = 2'd1;
  localparam logic [1:0] CMD_STAR      = 2'd2;
  localparam logic [1:0] CMD_END       = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] entry_index;
    logic [31:0] star_id;
    logic [15:0] quad_base;
    logic [7:0]  quad_count;
    logic [31:0] quad_id;
  } request_t;

  typedef struct packed {
    logic [31:0] field_number;
    logic [31:0] reported_quad;
    logic        has_quad;
    logic        last;
    logic        list_overflow;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;     // capture request
    logic star_wr;
    logic quad_wr;
    logic srch_init;
    logic srch_rd;      // read star table at mid
    logic srch_step;    // compare and narrow
    logic run_init;
    logic quad_rd;      // read quad store at run address
    logic scan_init;
    logic scan_step;    // compare one list entry
    logic vote_new;
    logic vote_bump;
    logic vote_drop;
    logic rep_init;
    logic rep_step;     // examine one entry for report
    logic emit_empty;
    logic field_done;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic       srch_empty;  // lo >= hi
    logic       srch_hit;
    logic       run_done;
    logic       scan_done;   // scanned all used entries
    logic       scan_hit;
    logic       list_full;
    logic       rep_done;
  } stat_t;

endpackage

// ----- rtl/fqvc_datapath.sv -----
// ----------------------------------------------------------------------------
// fqvc_datapath
// Star table, quad store, vote list and the registers the controller steps.
// ----------------------------------------------------------------------------
module fqvc_datapath import fqvc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_sel,
  input  logic [CFG_W-1:0] cfg_data,
  input  request_t   req_in,
  input  ctrl_t      ctrl,
  output stat_t      stat,
  output logic       result_valid,
  output result_t    result
);

  logic [31:0] star_ids   [STAR_DEPTH];
  logic [15:0] star_bases [STAR_DEPTH];
  logic [7:0]  star_cnts  [STAR_DEPTH];
  logic [31:0] quad_store [QUAD_DEPTH];
  logic [31:0] vote_ids   [VOTE_DEPTH];
  logic [7:0]  vote_cnts  [VOTE_DEPTH];

  request_t    req;
  logic [12:0] star_count;
  logic [7:0]  vote_threshold;
  logic [STAR_AW:0] lo, hi, mid;
  logic [31:0] rd_sid;
  logic [15:0] rd_base;
  logic [7:0]  rd_cnt;
  logic [15:0] run_base;
  logic [7:0]  run_cnt, run_off;
  logic [31:0] cur_qid;
  logic [31:0] rd_qid;
  logic        qid_zero;
  logic [VOTE_AW:0] vote_used;
  logic [VOTE_AW:0] ptr;
  logic [31:0] scan_id;
  logic [7:0]  scan_cnt;
  logic        scan_ok;
  logic        overflow_flag;
  logic [31:0] field_counter;
  logic        any_out;
  logic        rep_hit;
  logic [STAR_AW:0] n_eff;
  logic [15:0] run_addr;

  assign n_eff = (star_count > 13'(STAR_DEPTH)) ? (STAR_AW+1)'(STAR_DEPTH)
                                                 : (STAR_AW+1)'(star_count);
  assign run_addr = run_base + 16'(run_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      star_count <= '0;
      vote_threshold <= 8'd4;
    end else if (cfg_we) begin
      if (cfg_sel == REG_STAR_COUNT) star_count <= cfg_data[12:0];
      else vote_threshold <= cfg_data[7:0];
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ctrl.star_wr && req.entry_index < 16'(STAR_DEPTH)) begin
      star_ids[req.entry_index[STAR_AW-1:0]]   <= req.star_id;
      star_bases[req.entry_index[STAR_AW-1:0]] <= req.quad_base;
      star_cnts[req.entry_index[STAR_AW-1:0]]  <= req.quad_count;
    end
    if (ctrl.srch_rd) begin
      rd_sid  <= star_ids[mid[STAR_AW-1:0]];
      rd_base <= star_bases[mid[STAR_AW-1:0]];
      rd_cnt  <= star_cnts[mid[STAR_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.quad_wr && 17'(req.entry_index) < 17'(QUAD_DEPTH))
      quad_store[req.entry_index[QUAD_AW-1:0]] <= req.quad_id;
    if (ctrl.quad_rd) begin
      rd_qid   <= quad_store[run_addr[QUAD_AW-1:0]];
      qid_zero <= 17'(run_addr) >= 17'(QUAD_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.vote_new)
      vote_ids[vote_used[VOTE_AW-1:0]] <= cur_qid;
    if (ctrl.vote_new)
      vote_cnts[vote_used[VOTE_AW-1:0]] <= 8'd1;
    else if (ctrl.vote_bump && scan_cnt != 8'hFF)
      vote_cnts[ptr[VOTE_AW-1:0]] <= scan_cnt + 8'd1;
    scan_id  <= vote_ids[ptr[VOTE_AW-1:0]];
    scan_cnt <= vote_cnts[ptr[VOTE_AW-1:0]];
  end

  assign cur_qid = qid_zero ? 32'd0 : rd_qid;

  always_ff @(posedge clk) begin
    if (ctrl.load_req) req <= req_in;
    if (ctrl.srch_init) begin
      lo <= '0;
      hi <= n_eff;
    end else if (ctrl.srch_step && rd_sid != req.star_id) begin
      if (req.star_id < rd_sid) hi <= mid;
      else lo <= mid + 1'b1;
    end
    if (ctrl.run_init) begin
      run_base <= rd_base;
      run_cnt  <= rd_cnt;
      run_off  <= '0;
    end else if (ctrl.vote_new || ctrl.vote_bump || ctrl.vote_drop) begin
      run_off <= run_off + 8'd1;
    end
  end

  assign mid = lo + ((hi - lo) >> 1);

  // ptr walks the list; scan_ok says scan_id/scan_cnt belong to ptr
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      scan_ok <= 1'b0;
    end else if (ctrl.scan_init || ctrl.rep_init) begin
      ptr <= '0;
      scan_ok <= 1'b0;
    end else if (ctrl.scan_step || ctrl.rep_step) begin
      if (scan_ok) ptr <= ptr + 1'b1;
      scan_ok <= !scan_ok;
    end
  end

  assign rep_hit = ctrl.rep_step && scan_ok && scan_cnt >= vote_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_used <= '0;
      overflow_flag <= 1'b0;
      field_counter <= '0;
      any_out <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= rep_hit || (ctrl.emit_empty && !any_out);
      if (ctrl.vote_new) vote_used <= vote_used + 1'b1;
      if (ctrl.vote_drop) overflow_flag <= 1'b1;
      if (ctrl.rep_init) any_out <= 1'b0;
      if (rep_hit) begin
        any_out <= 1'b1;
        result.field_number  <= field_counter;
        result.reported_quad <= scan_id;
        result.has_quad      <= 1'b1;
        result.last          <= (ptr + 1'b1) == vote_used;
        result.list_overflow <= overflow_flag;
      end
      if (ctrl.emit_empty && !any_out) begin
        result.field_number  <= field_counter;
        result.reported_quad <= '0;
        result.has_quad      <= 1'b0;
        result.last          <= 1'b1;
        result.list_overflow <= overflow_flag;
      end
      if (ctrl.field_done) begin
        vote_used <= '0;
        overflow_flag <= 1'b0;
        field_counter <= field_counter + 32'd1;
      end
    end
  end

  // A hit on a non-final list entry leaves last low; the last reporting entry is
  // found in fqvc_report, which holds one result back until a newer one or the flush.
  assign stat.command    = req.command;
  assign stat.srch_empty = lo >= hi;
  assign stat.srch_hit   = rd_sid == req.star_id;
  assign stat.run_done   = run_off == run_cnt;
  assign stat.scan_done  = ptr == vote_used;
  assign stat.scan_hit   = scan_ok && scan_id == cur_qid;
  assign stat.list_full  = vote_used == (VOTE_AW+1)'(VOTE_DEPTH);
  assign stat.rep_done   = ptr == vote_used;

endmodule

// ----- rtl/fqvc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fqvc_ctrl
// Sequencer for loads, star search, quad run voting and field report.
// ----------------------------------------------------------------------------
module fqvc_ctrl import fqvc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output ctrl_t ctrl
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_SRD   = 10'b0000000100,
    S_SCMP  = 10'b0000001000,
    S_QRD   = 10'b0000010000,
    S_QWAIT = 10'b0000100000,
    S_SCAN  = 10'b0001000000,
    S_REP   = 10'b0010000000,
    S_EMPTY = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = state != S_IDLE;

  always_comb begin
    ctrl = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load_req = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.command)
          CMD_LOAD_STAR: begin ctrl.star_wr = 1'b1; state_next = S_IDLE; end
          CMD_LOAD_QUAD: begin ctrl.quad_wr = 1'b1; state_next = S_IDLE; end
          CMD_STAR: begin ctrl.srch_init = 1'b1; state_next = S_SRD; end
          default: begin ctrl.rep_init = 1'b1; state_next = S_REP; end
        endcase
      end
      S_SRD: begin
        if (stat.srch_empty) state_next = S_IDLE;
        else begin
          ctrl.srch_rd = 1'b1;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        ctrl.srch_step = 1'b1;
        if (stat.srch_hit) begin
          ctrl.run_init = 1'b1;
          state_next = S_QRD;
        end else state_next = S_SRD;
      end
      S_QRD: begin
        if (stat.run_done) state_next = S_IDLE;
        else begin
          ctrl.quad_rd = 1'b1;
          state_next = S_QWAIT;
        end
      end
      S_QWAIT: begin
        ctrl.scan_init = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          ctrl.vote_bump = 1'b1;
          state_next = S_QRD;
        end else if (stat.scan_done) begin
          if (stat.list_full) ctrl.vote_drop = 1'b1;
          else ctrl.vote_new = 1'b1;
          state_next = S_QRD;
        end else ctrl.scan_step = 1'b1;
      end
      S_REP: begin
        if (stat.rep_done) state_next = S_EMPTY;
        else ctrl.rep_step = 1'b1;
      end
      S_EMPTY: begin
        ctrl.emit_empty = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        ctrl.field_done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/fqvc_report.sv -----
// ----------------------------------------------------------------------------
// fqvc_report
// Output stage: holds one qualifying result back so the final one of a field
// can be marked last, and emits the empty marker when none qualified.
// ----------------------------------------------------------------------------
module fqvc_report import fqvc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_res,
  input  logic    flush,
  output logic    done,
  output result_t result,
  output logic    result_valid
);

  logic    held;
  result_t held_res;
  result_t rel_res;
  logic    flushing;

  // a held result is last only when the field ends with no newer one behind it
  always_comb begin
    rel_res = held_res;
    rel_res.last = !in_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      result_valid <= 1'b0;
      flushing <= 1'b0;
    end else begin
      flushing <= !in_valid && flush && !flushing;
      if (in_valid) begin
        // release the previous held one, hold the new one
        result_valid <= held || !in_res.has_quad;
        held <= in_res.has_quad;
        held_res <= in_res;
        if (in_res.has_quad) result <= rel_res;
        else result <= in_res;
      end else if (flush && !flushing) begin
        result_valid <= held;
        result <= rel_res;
        held <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  assign done = flushing;

endmodule

// ----- rtl/field_quad_vote_counter.sv -----
// ----------------------------------------------------------------------------
// field_quad_vote_counter
// Star lookup and per-field quad voting with thresholded report.
// ----------------------------------------------------------------------------
// Busy stays high while a load, a field star or an end of field is in work; a field
// star runs a binary search probe by probe, then per quad reads it and scans the list.
// End of field walks the used entries and emits the qualifying ones, or the empty
// marker; results are not throttled.
// One request at a time: start is taken only while busy is low.
// Reset clears the list, field number, flags and star count and sets the threshold to 4; tables are kept.
module field_quad_vote_counter import fqvc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  request_t         request,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             strobe,
  output result_t          result
);

  ctrl_t   ctrl;
  stat_t   stat;
  logic    dp_valid;
  result_t dp_res;
  logic    ctl_busy;
  logic    flush_done;

  // hold off a request while the final result of a field goes out
  fqvc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start && !flush_done),
    .stat (stat),
    .busy (ctl_busy),
    .ctrl (ctrl)
  );

  fqvc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_sel     (cfg_addr),
    .cfg_data    (cfg_data),
    .req_in      (request),
    .ctrl        (ctrl),
    .stat        (stat),
    .result_valid(dp_valid),
    .result      (dp_res)
  );

  fqvc_report u_rep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dp_valid),
    .in_res      (dp_res),
    .flush       (ctrl.field_done),
    .done        (flush_done),
    .result      (result),
    .result_valid(strobe)
  );

  assign busy = ctl_busy || flush_done;

endmodule

// ----- rtl/fqvc_checker.sv -----
// ----------------------------------------------------------------------------
// fqvc_checker
// Port-level checks for the field quad vote counter.
// ----------------------------------------------------------------------------
module fqvc_checker import fqvc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    strobe,
  input result_t result
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after request");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.has_quad |-> result.last && result.reported_quad == '0)
    else $error("empty marker malformed");

  a_field_steps: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last ##1 strobe |-> result.field_number != $past(result.field_number))
    else $error("field number did not advance");

  a_no_strobe_reset: assert property (@(posedge clk)
    rst |=> !strobe) else $error("result during reset");

endmodule

bind field_quad_vote_counter fqvc_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe), .result(result)
);

// ----- tb/field_quad_vote_counter_tb.sv -----
// ----------------------------------------------------------------------------
// field_quad_vote_counter_tb
// Loads the star table and the quad regions, then runs directed and random
// fields. Every accepted request updates a local model of the tables and the
// vote list. Each result, empty markers included, is checked against the queue of
// expected reports.
// ----------------------------------------------------------------------------
module field_quad_vote_counter_tb;
  import fqvc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTAR = 16;
  localparam int QLOW  = 96;
  localparam int QHIGH = 32;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  request_t         request;
  logic             cfg_we;
  logic [0:0]       cfg_addr;
  logic [CFG_W-1:0] cfg_data;
  logic             strobe;
  result_t          result;

  field_quad_vote_counter u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .strobe(strobe), .result(result)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // local copy of the block's state
  bit [31:0] tab_id   [STAR_DEPTH];
  bit [15:0] tab_base [STAR_DEPTH];
  bit [7:0]  tab_cnt  [STAR_DEPTH];
  bit [31:0] quad_mem [QUAD_DEPTH];
  bit [31:0] list_id  [VOTE_DEPTH];
  bit [7:0]  list_cnt [VOTE_DEPTH];
  int        list_used;
  bit [31:0] field_no;
  bit        dropped;
  int        star_n;
  bit [7:0]  thresh;

  request_t  pending[$];
  result_t   field_reports[$];
  int        errors;
  int        idle_pct;

  function automatic void apply_request(request_t r);
    int lo, hi, mid, n, k;
    bit hit, seen;
    bit [15:0] addr;
    bit [31:0] q;
    case (r.command)
      CMD_LOAD_STAR: begin
        if (r.entry_index < STAR_DEPTH) begin
          tab_id[r.entry_index]   = r.star_id;
          tab_base[r.entry_index] = r.quad_base;
          tab_cnt[r.entry_index]  = r.quad_count;
        end
      end
      CMD_LOAD_QUAD: quad_mem[r.entry_index] = r.quad_id;
      CMD_STAR: begin
        n = star_n < STAR_DEPTH ? star_n : STAR_DEPTH;
        lo = 0;
        hi = n;
        hit = 0;
        mid = 0;
        while (lo < hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          if (tab_id[mid] == r.star_id) hit = 1;
          else if (r.star_id < tab_id[mid]) hi = mid;
          else lo = mid + 1;
        end
        if (hit) begin
          for (int j = 0; j < tab_cnt[mid]; j++) begin
            addr = tab_base[mid] + 16'(j);
            q = quad_mem[addr];
            seen = 0;
            for (k = 0; k < list_used && !seen; k++) begin
              if (list_id[k] == q) begin
                seen = 1;
                if (list_cnt[k] != 8'hFF) list_cnt[k]++;
              end
            end
            if (!seen) begin
              if (list_used < VOTE_DEPTH) begin
                list_id[list_used]  = q;
                list_cnt[list_used] = 1;
                list_used++;
              end else begin
                dropped = 1;
              end
            end
          end
        end
      end
      CMD_END: begin
        result_t e;
        n = field_reports.size();
        for (k = 0; k < list_used; k++) begin
          if (list_cnt[k] >= thresh) begin
            e = '{field_no, list_id[k], 1'b1, 1'b0, dropped};
            field_reports.push_back(e);
          end
        end
        if (field_reports.size() == n) begin
          e = '{field_no, 32'd0, 1'b0, 1'b1, dropped};
          field_reports.push_back(e);
        end else begin
          field_reports[field_reports.size()-1].last = 1'b1;
        end
        list_used = 0;
        dropped = 0;
        field_no++;
      end
    endcase
  endfunction

  // driver: hold a request until accepted, then advance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(request);
        void'(pending.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start   <= 1'b1;
        request <= pending[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(string nm, longint unsigned e, longint unsigned g);
    if (e != g) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, nm, e, g);
      errors++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst && strobe) begin
      if (field_reports.size() == 0) begin
        $display("%0t: unexpected report: expected none, actual %p", $realtime, result);
        errors++;
      end else begin
        e = field_reports.pop_front();
        check_field("field_number", e.field_number, result.field_number);
        check_field("reported_quad", e.reported_quad, result.reported_quad);
        check_field("has_quad", e.has_quad, result.has_quad);
        check_field("last", e.last, result.last);
        check_field("list_overflow", e.list_overflow, result.list_overflow);
      end
    end
  end

  task automatic wait_idle();
    wait (pending.size() == 0);
    do @(negedge clk); while (start || busy || field_reports.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] a, int d);
    wait_idle();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= CFG_W'(d);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (a == REG_STAR_COUNT) star_n = d;
    else thresh = 8'(d);
  endtask

  function automatic request_t noise_req();
    request_t r;
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    r = raw[$bits(request_t)-1:0];
    return r;
  endfunction

  function automatic void push_star(int idx, bit [31:0] id, bit [15:0] base, bit [7:0] cnt);
    request_t r;
    r = noise_req();
    r.command     = CMD_LOAD_STAR;
    r.entry_index = 16'(idx);
    r.star_id     = id;
    r.quad_base   = base;
    r.quad_count  = cnt;
    pending.push_back(r);
  endfunction

  function automatic void push_quad(int addr, bit [31:0] q);
    request_t r;
    r = noise_req();
    r.command     = CMD_LOAD_QUAD;
    r.entry_index = 16'(addr);
    r.quad_id     = q;
    pending.push_back(r);
  endfunction

  function automatic void push_cmd(logic [1:0] c, bit [31:0] key);
    request_t r;
    r = noise_req();
    r.command = c;
    r.star_id = key;
    pending.push_back(r);
  endfunction

  // keep runs inside the loaded quad regions
  function automatic bit [15:0] pick_base();
    return $urandom_range(1) ? 16'($urandom_range(QLOW - 11))
                             : 16'hFFE0 + 16'($urandom_range(QHIGH - 1));
  endfunction

  function automatic bit [7:0] pick_count();
    return 8'($urandom_range(10));
  endfunction

  function automatic bit [31:0] star_key(int idx);
    return idx == 0 ? 32'd0 : idx == NSTAR-1 ? 32'hFFFF_FFFF : 32'(idx * 1000 + 500);
  endfunction

  initial begin
    int lim, cnt, k;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    errors = 0;
    idle_pct = 0;
    list_used = 0;
    field_no = 0;
    dropped = 0;
    star_n = 0;
    thresh = 8'd4;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // preload: sorted table and quad regions
    for (int i = 0; i < NSTAR; i++) begin
      case (i)
        1: push_star(i, star_key(i), 16'hFFE0, 8'd32);
        2: push_star(i, star_key(i), 16'hFFE0, 8'd128);
        3: push_star(i, star_key(i), 16'h0000, 8'(QLOW));
        default: push_star(i, star_key(i), pick_base(), pick_count());
      endcase
    end
    for (int a = 0; a < QLOW; a++) push_quad(a, 32'(a % 97));
    for (int a = 16'hFFE0; a <= 16'hFFFF; a++) push_quad(a, 32'hFFFF_FFFF);
    write_reg(REG_STAR_COUNT, NSTAR);
    write_reg(REG_VOTE_THRESHOLD, 4);

    // ends of the table, a miss, an ignored load
    push_cmd(CMD_STAR, 32'd0);
    push_cmd(CMD_STAR, 32'hFFFF_FFFF);
    push_cmd(CMD_STAR, 32'd7);
    push_star(16'hFFFF, 32'd5, 16'h1234, 8'd9);
    push_cmd(CMD_STAR, star_key(2));
    push_cmd(CMD_END, 0);
    push_cmd(CMD_END, 0);
    // saturation at the top threshold
    write_reg(REG_VOTE_THRESHOLD, 255);
    for (int i = 0; i < 8; i++) push_cmd(CMD_STAR, star_key(1));
    push_cmd(CMD_END, 0);
    // full list drops new quads
    write_reg(REG_VOTE_THRESHOLD, 1);
    push_cmd(CMD_STAR, star_key(3));
    push_cmd(CMD_STAR, star_key(2));
    push_cmd(CMD_END, 0);
    // empty table finds nothing
    write_reg(REG_STAR_COUNT, 0);
    push_cmd(CMD_STAR, star_key(5));
    push_cmd(CMD_END, 0);
    // whole loaded table
    write_reg(REG_STAR_COUNT, NSTAR);
    write_reg(REG_VOTE_THRESHOLD, 2);
    push_cmd(CMD_STAR, star_key(NSTAR - 1));
    push_cmd(CMD_STAR, star_key(10));
    push_cmd(CMD_END, 0);

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_STAR_COUNT, $urandom_range(1, NSTAR));
      write_reg(REG_VOTE_THRESHOLD, ($urandom_range(5) == 0) ? 255 : $urandom_range(1, 6));
      idle_pct = (ph == 1) ? 77 : (ph == 3) ? 23 : 0;
      lim = star_n < NSTAR ? star_n : NSTAR;
      cnt = 0;
      while (cnt < 40) begin
        for (int s = $urandom_range(1, 6); s > 0; s--) begin
          k = $urandom_range(99);
          if (k < 80) begin
            push_cmd(CMD_STAR, tab_id[$urandom_range(lim - 1)]);
          end else if (k < 88) begin
            push_cmd(CMD_STAR, $urandom());
          end else if (k < 94) begin
            push_quad($urandom_range(1) ? $urandom_range(QLOW - 1)
                                        : 16'hFFE0 + $urandom_range(QHIGH - 1),
                      $urandom());
          end else begin
            // mostly out of range; an in-range hit may unsort the table
            push_star($urandom_range(16'hFFFF), $urandom(), pick_base(), pick_count());
          end
          cnt++;
        end
        push_cmd(CMD_END, 0);
        cnt++;
      end
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
